// ===== src/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scan block.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 32;
  localparam int unsigned OFFSET_BITS_DEF       = 32;

  localparam int unsigned PAT_BYTES    = 32;  // pattern storage, fixed by the register map
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned MATCH_OFF_W  = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_WILD_MASK = 3'd4,
    CFG_PAT_LEN   = 3'd5
  } cfg_idx_e;

  // programmed pattern as seen by the compare logic
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] bytes;
    logic [PAT_BYTES-1:0]      wild;
    logic [LEN_W-1:0]          len;
  } pattern_t;

  // status of the item held in the window stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_t;

endpackage

// ===== src/mbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern bytes, wildcard mask and length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mbps_pkg::pattern_t                pattern_o
);
  import mbps_pkg::*;

  logic [PAT_BYTES-1:0][7:0] bytes_q;
  logic [PAT_BYTES-1:0]      wild_q;
  logic [LEN_W-1:0]          len_q;
  logic                      wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      wild_q  <= '0;
      len_q   <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_0_7:   bytes_q[7:0]   <= cfg_data_i;
        CFG_PAT_8_15:  bytes_q[15:8]  <= cfg_data_i;
        CFG_PAT_16_23: bytes_q[23:16] <= cfg_data_i;
        CFG_PAT_24_31: bytes_q[31:24] <= cfg_data_i;
        CFG_WILD_MASK: wild_q         <= cfg_data_i[PAT_BYTES-1:0];
        CFG_PAT_LEN:   len_q          <= cfg_data_i[LEN_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign pattern_o.bytes = bytes_q;
  assign pattern_o.wild  = wild_q;
  assign pattern_o.len   = len_q;

endmodule

// ===== src/mbps_window.sv =====
// ----------------------------------------------------------------------------
// mbps_window
// Input stage: byte window shift register, saturating byte count and the
// held item status.
// ----------------------------------------------------------------------------
module mbps_window #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  input  logic                              take_i,
  output mbps_pkg::stage_t                  stage_o,
  output logic [MAX_PATTERN_BYTES-1:0][7:0] window_o,
  output logic [OFFSET_BITS-1:0]            count_o
);
  import mbps_pkg::*;

  logic [MAX_PATTERN_BYTES-1:0][7:0] win_q, win_d, win_base;
  logic [OFFSET_BITS-1:0]            cnt_q, cnt_d, cnt_base;
  logic                              valid_q, last_q, clr_q;
  logic                              accept;

  assign in_ready_o = ~valid_q | take_i;
  assign accept     = in_valid_i & in_ready_o;

  // the item after a last byte starts from a cleared window and count
  always_comb begin
    win_base = clr_q ? '0 : win_q;
    cnt_base = clr_q ? '0 : cnt_q;
    win_d[0] = data_byte_i;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      win_d[i] = win_base[i-1];
    end
    cnt_d = (&cnt_base) ? cnt_base : cnt_base + OFFSET_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      if (accept) begin
        win_q   <= win_d;
        cnt_q   <= cnt_d;
        last_q  <= last_byte_i;
        clr_q   <= last_byte_i;
        valid_q <= 1'b1;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.last  = last_q;
  assign window_o      = win_q;
  assign count_o       = cnt_q;

endmodule

// ===== src/mbps_match.sv =====
// ----------------------------------------------------------------------------
// mbps_match
// Window compare against the masked pattern, first-match tracking and the
// result register.
// ----------------------------------------------------------------------------
module mbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mbps_pkg::pattern_t                pattern_i,
  input  mbps_pkg::stage_t                  stage_i,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0] window_i,
  input  logic [OFFSET_BITS-1:0]            count_i,
  output logic                              take_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [mbps_pkg::MATCH_OFF_W-1:0]  match_offset_o
);
  import mbps_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [LEN_W-1:0]       len_eff;
  logic [OFFSET_BITS-1:0] len_ext, offset;
  logic [63:0]            offset_wide;
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  logic                   hit, emit;
  logic                   reported_q;
  logic                   out_valid_q, found_q;
  logic [MATCH_OFF_W-1:0] offset_q;

  always_comb begin
    logic [LEN_W-1:0] age;
    len_eff = (pattern_i.len > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES)
                                                         : pattern_i.len;
    // pattern position i lines up with the byte of age len-1-i
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      age = len_eff - LEN_W'(1) - LEN_W'(i);
      pos_ok[i] = (LEN_W'(i) >= len_eff) || pattern_i.wild[i] ||
                  (window_i[age[IDX_W-1:0]] == pattern_i.bytes[i]);
    end
    len_ext     = OFFSET_BITS'(len_eff);
    offset      = count_i - len_ext;
    offset_wide = 64'(offset);
    hit  = ~reported_q && (len_eff != '0) && (count_i >= len_ext) && (&pos_ok);
    emit = hit || (stage_i.last && ~reported_q);
  end

  assign take_o = stage_i.valid & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        reported_q <= stage_i.last ? 1'b0 : (reported_q | hit);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take_o && emit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      found_q  <= hit;
      offset_q <= hit ? offset_wide[MATCH_OFF_W-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

// ===== src/masked_byte_pattern_scan.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Finds the first match of a wildcard byte pattern in a byte stream and
// reports found with its start offset, or not-found at the end of a buffer.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_ready_o | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_ready_i | found_o, match_offset_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out is not stalled; an accepted item
// lands in the window stage, and the compare then loads the result register
// that drives out once that register is free or its result is being accepted.
// While a result waits, the input takes at most one more item into the
// window stage and then stalls until the result is accepted. Reset clears
// window, count and match state; cfg is always ready.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [mbps_pkg::MATCH_OFF_W-1:0] match_offset_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mbps_pkg::*;

  pattern_t                          pattern;
  stage_t                            stage;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [OFFSET_BITS-1:0]            count;
  logic                              take;

  mbps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern)
  );

  mbps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (take),
    .stage_o     (stage),
    .window_o    (window),
    .count_o     (count)
  );

  mbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pattern_i      (pattern),
    .stage_i        (stage),
    .window_i       (window),
    .count_i        (count),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

endmodule

// ===== tb/masked_byte_pattern_scan_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_tb
// Streams byte buffers through the wildcard pattern scanner under random
// handshake gaps and back pressure. A scan model in the bench tracks the byte
// window, the buffer count and the found flag, and every result is compared
// against it in order.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_tb;
  import mbps_pkg::*;

  localparam int unsigned WIN_BYTES     = 32;
  localparam int unsigned RANDOM_ITEMS  = 1650;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_GAP       = 10;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                   found;
    logic [MATCH_OFF_W-1:0] offset;
  } scan_result_t;

  typedef enum int unsigned {
    SHAPE_NOISE,
    SHAPE_CLEAN,
    SHAPE_BROKEN,
    SHAPE_TWICE
  } buffer_shape_e;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i    = '0;
  logic                   last_byte_i    = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b0;
  logic                   found_o;
  logic [MATCH_OFF_W-1:0] match_offset_o;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;

  masked_byte_pattern_scan u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scan model state and the results it still owes
  scan_result_t                  pending_results[$];
  logic [7:0]                    model_window [WIN_BYTES] = '{default: 8'h00};
  logic [OFFSET_BITS_DEF-1:0]    model_seen     = '0;
  logic                          model_reported = 1'b0;
  logic [CFG_DATA_W-1:0]         model_pat_word [4] = '{default: '0};
  logic [31:0]                   model_wild     = '0;
  logic [LEN_W-1:0]              model_len      = '0;

  // signature as the stimulus side sees it
  logic [PAT_BYTES-1:0][7:0]     sig_bytes = '0;
  logic [31:0]                   sig_wild  = '0;
  int unsigned                   sig_len   = 0;

  bit              in_burst  = 1'b0;
  bit              out_burst = 1'b0;
  int unsigned     stall_left = 0;
  longint unsigned cycle_cnt  = 0;
  int unsigned     errors = 0, results_seen = 0, found_seen = 0;
  int unsigned     bytes_sent = 0, settings_run = 0;

  function automatic void flag_error(input string msg);
    if (errors < MAX_REPORTS)
      $display("[%0t] %s", $time, msg);
    errors++;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_PAT_0_7:   model_pat_word[0] = d;
      CFG_PAT_8_15:  model_pat_word[1] = d;
      CFG_PAT_16_23: model_pat_word[2] = d;
      CFG_PAT_24_31: model_pat_word[3] = d;
      CFG_WILD_MASK: model_wild = d[31:0];
      CFG_PAT_LEN:   model_len = d[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    int unsigned  len;
    int unsigned  i;
    bit           hit;
    scan_result_t res;
    for (i = WIN_BYTES - 1; i > 0; i--)
      model_window[i] = model_window[i - 1];
    model_window[0] = b;
    if (model_seen != '1)
      model_seen++;
    len = (model_len > WIN_BYTES) ? WIN_BYTES : model_len;
    if (!model_reported && len != 0 && model_seen >= len) begin
      hit = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window span
      for (i = 0; i < len; i++)
        if (!model_wild[i] &&
            model_window[len - 1 - i] != model_pat_word[i / 8][8 * (i % 8) +: 8])
          hit = 1'b0;
      if (hit) begin
        model_reported = 1'b1;
        res.found  = 1'b1;
        res.offset = model_seen - len;
        pending_results.push_back(res);
      end
    end
    if (last) begin
      if (!model_reported) begin
        res = '0;
        pending_results.push_back(res);
      end
      model_window   = '{default: 8'h00};
      model_seen     = '0;
      model_reported = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    scan_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        scan_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (found_o)
          found_seen++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result: found %0b offset %0d",
                               found_o, match_offset_o));
        end else begin
          want = pending_results.pop_front();
          if (found_o !== want.found)
            flag_error($sformatf("found: expected %0b, got %0b", want.found, found_o));
          if (match_offset_o !== want.offset)
            flag_error($sformatf("match_offset: expected %0d, got %0d",
                                 want.offset, match_offset_o));
        end
      end
    end
  end

  // receiver stalls, drawn after each result and now and then while idle
  always @(posedge clk_i) begin
    if ((out_valid_o && out_ready_i) ||
        (!out_valid_o && stall_left == 0 && $urandom_range(0, 3) == 0))
      stall_left = out_burst ? 0 : $urandom_range(0, MAX_GAP);
    else if (stall_left != 0)
      stall_left--;
    out_ready_i <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid is left high after the item so back-to-back items stay high
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i <= b;
    last_byte_i <= last;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // loads sig_bytes plus the given mask and length words, junk index first
  task automatic program_scan(input logic [CFG_DATA_W-1:0] len_word,
                              input logic [CFG_DATA_W-1:0] wild_word);
    write_reg(CFG_IDX_W'(CFG_PAT_LEN + 1 + $urandom_range(0, 1)), {$urandom, $urandom});
    write_reg(CFG_PAT_0_7,   sig_bytes[0 +: 8]);
    write_reg(CFG_PAT_8_15,  sig_bytes[8 +: 8]);
    write_reg(CFG_PAT_16_23, sig_bytes[16 +: 8]);
    write_reg(CFG_PAT_24_31, sig_bytes[24 +: 8]);
    write_reg(CFG_WILD_MASK, wild_word);
    write_reg(CFG_PAT_LEN,   len_word);
    cfg_valid_i <= 1'b0;
    sig_wild = wild_word[31:0];
    sig_len  = (len_word[LEN_W-1:0] > PAT_BYTES) ? PAT_BYTES : len_word[LEN_W-1:0];
    settings_run++;
  endtask

  function automatic void plant_signature(ref logic [7:0] stream_q[$],
                                          input int unsigned pos);
    for (int unsigned i = 0; i < sig_len; i++)
      if (!sig_wild[i])
        stream_q[pos + i] = sig_bytes[i];
  endfunction

  task automatic scan_buffer();
    logic [7:0]    stream_q[$];
    buffer_shape_e shape;
    int unsigned   roll, n, pos, i;
    roll  = $urandom_range(0, 9);
    shape = (roll < 3) ? SHAPE_NOISE : (roll < 7) ? SHAPE_CLEAN :
            (roll < 9) ? SHAPE_BROKEN : SHAPE_TWICE;
    if (sig_len == 0)
      shape = SHAPE_NOISE;
    n = (shape == SHAPE_NOISE) ? $urandom_range(1, 24) : sig_len + $urandom_range(0, 12);
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 4) == 0);
    // half the filler comes from the signature itself for near misses
    for (i = 0; i < n; i++)
      stream_q.push_back($urandom_range(0, 1) ? sig_bytes[$urandom_range(0, PAT_BYTES - 1)]
                                              : 8'($urandom));
    if (shape != SHAPE_NOISE) begin
      case ($urandom_range(0, 3))
        0:       pos = 0;
        1:       pos = n - sig_len;
        default: pos = $urandom_range(0, n - sig_len);
      endcase
      plant_signature(stream_q, pos);
      if (shape == SHAPE_TWICE)
        plant_signature(stream_q, $urandom_range(0, n - sig_len));
      if (shape == SHAPE_BROKEN)
        stream_q[pos + $urandom_range(0, sig_len - 1)] ^= 8'($urandom_range(1, 255));
    end
    for (i = 0; i < n; i++)
      send_byte(stream_q[i], i == n - 1);
  endtask

  task automatic test_zero_length();
    sig_bytes = '0;
    // low six bits clear, so the length is zero even with an all-zero window
    program_scan(64'hffff_ffff_ffff_ffc0, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_single_byte();
    sig_bytes    = '0;
    sig_bytes[0] = 8'hff;
    program_scan(64'd1, 64'hffff_ffff_0000_0000);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);   // match on the last byte
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_later_match();
    sig_bytes    = '0;
    sig_bytes[0] = 8'haa;
    sig_bytes[2] = 8'h55;
    program_scan(64'd3, 64'h2);
    send_byte(8'haa, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);   // second hit must stay silent
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_scan();
    logic [CFG_DATA_W-1:0] len_word, wild_word;
    int unsigned           phase, run_start, phase_start;
    phase     = 0;
    run_start = bytes_sent;
    while (bytes_sent - run_start < RANDOM_ITEMS) begin
      for (int k = 0; k < PAT_BYTES; k++)
        sig_bytes[k] = 8'($urandom);
      len_word  = {$urandom, $urandom};
      wild_word = {$urandom, $urandom & $urandom & $urandom};
      case (phase)
        0: begin   // full length, no wildcards
          sig_bytes = '1;
          len_word[LEN_W-1:0] = LEN_W'(PAT_BYTES);
          wild_word[31:0] = '0;
        end
        1: begin   // oversized length, every position a wildcard
          sig_bytes = '0;
          len_word[LEN_W-1:0] = '1;
          wild_word[31:0] = '1;
        end
        2: len_word[LEN_W-1:0] = '0;
        3: len_word[LEN_W-1:0] = LEN_W'($urandom_range(PAT_BYTES + 1, 62));
        default: begin
          len_word[LEN_W-1:0] = ($urandom_range(0, 9) < 7) ?
                                LEN_W'($urandom_range(1, 8)) :
                                LEN_W'($urandom_range(1, PAT_BYTES));
          if ($urandom_range(0, 3) == 0)
            wild_word[31:0] = '0;
        end
      endcase
      program_scan(len_word, wild_word);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS && bytes_sent - run_start < RANDOM_ITEMS)
        scan_buffer();
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_length();
    test_single_byte();
    test_later_match();
    test_random_scan();
    wait_idle();
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("scanned %0d bytes under %0d pattern settings", bytes_sent, settings_run);
    $display("checked %0d results: %0d found, %0d not found",
             results_seen, found_seen, results_seen - found_seen);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
